>>> rtl/sptg_pkg.sv
// ----------------------------------------------------------------------------
// sptg_pkg
// shared types for the sparse table range gcd block
// ----------------------------------------------------------------------------
package sptg_pkg;

  localparam int unsigned IdxBits = 10;
  localparam int unsigned LenBits = IdxBits + 1;
  localparam int unsigned KBits   = $clog2(LenBits);

  localparam logic ReqLoad  = 1'b0;
  localparam logic ReqQuery = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [31:0]        value;
    logic               last_element;
    logic [IdxBits-1:0] left_index;
    logic [IdxBits-1:0] right_index;
  } sptg_in_t;

  typedef struct packed {
    logic [31:0] gcd_value;
    logic        error_flag;
    logic        overflow_flag;
  } sptg_out_t;

  typedef enum logic [1:0] {
    RD_Q_LO,
    RD_Q_HI,
    RD_B_LO,
    RD_B_HI
  } rd_sel_t;

  typedef struct packed {
    logic    cap;
    logic    opa_ld;
    logic    gcd_start;
    logic    wr_build;
    logic    next_row;
    logic    next_level;
    logic    bld_init;
    logic    bld_done;
    logic    out_ld;
    rd_sel_t rd_sel;
  } sptg_cmd_t;

  typedef struct packed {
    logic q_ok;
    logic lvl_ok;
    logic row_ok;
    logic gcd_done;
    logic out_free;
  } sptg_sts_t;

endpackage

>>> rtl/sptg_gcd.sv
// ----------------------------------------------------------------------------
// sptg_gcd
// iterative binary gcd, one reduction step per cycle
// ----------------------------------------------------------------------------
module sptg_gcd #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] a,
  input  logic [VALUE_BITS-1:0] b,
  output logic                  busy,
  output logic                  done,
  output logic [VALUE_BITS-1:0] result
);

  localparam int unsigned KW = $clog2(VALUE_BITS + 1);

  logic                  run_r;
  logic                  done_r;
  logic [VALUE_BITS-1:0] a_r;
  logic [VALUE_BITS-1:0] b_r;
  logic [VALUE_BITS-1:0] res_r;
  logic [KW-1:0]         k_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && (a_r == '0 || b_r == '0)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
      k_r <= '0;
    end else if (run_r) begin
      priority if (a_r == '0 || b_r == '0) begin
        res_r <= (a_r | b_r) << k_r;
      end else if (!a_r[0] && !b_r[0]) begin
        a_r <= a_r >> 1;
        b_r <= b_r >> 1;
        k_r <= k_r + KW'(1);
      end else if (!a_r[0]) begin
        a_r <= a_r >> 1;
      end else if (!b_r[0]) begin
        b_r <= b_r >> 1;
      end else if (a_r >= b_r) begin
        a_r <= (a_r - b_r) >> 1;
      end else begin
        b_r <= (b_r - a_r) >> 1;
      end
    end
  end

  assign busy   = run_r;
  assign done   = done_r;
  assign result = res_r;

endmodule

>>> rtl/sptg_dp.sv
// ----------------------------------------------------------------------------
// sptg_dp
// datapath: table memory, counters, query decode, gcd unit, result register
// ----------------------------------------------------------------------------
module sptg_dp #(
  parameter int unsigned MAX_ENTRIES = 1024,
  parameter int unsigned LEVELS      = 11,
  parameter int unsigned VALUE_BITS  = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sptg_pkg::sptg_in_t in_data,
  input  logic               out_stall,
  output logic               out_valid,
  output sptg_pkg::sptg_out_t out_data,
  input  sptg_pkg::sptg_cmd_t cmd,
  output sptg_pkg::sptg_sts_t sts
);
  import sptg_pkg::*;

  localparam int unsigned DEPTH = LEVELS * MAX_ENTRIES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned LVW   = $clog2(LEVELS + 1);
  localparam int unsigned WW    = ((CW > LEVELS) ? CW : LEVELS) + 1;
  localparam int unsigned AXW   = AW + WW + LenBits;
  localparam int unsigned VB    = VALUE_BITS;

  logic [VB-1:0]      mem [DEPTH];
  logic [VB-1:0]      rd_data_r;
  logic [CW-1:0]      cnt_r;
  logic               ready_r;
  logic               open_r;
  logic               ovf_r;
  logic [LVW-1:0]     lvl_r;
  logic [CW-1:0]      idx_r;
  logic [IdxBits-1:0] ql_r;
  logic [IdxBits-1:0] qr_r;
  logic [VB-1:0]      opa_r;
  logic               out_valid_r;
  sptg_out_t          out_r;

  logic [CW-1:0]      eff_cnt;
  logic               room;
  logic [VB-1:0]      load_val;
  logic [VB+31:0]     load_ext;
  logic [LenBits-1:0] len;
  logic [KBits-1:0]   k;
  logic [AXW-1:0]     q_lo;
  logic [AXW-1:0]     q_hi;
  logic [AXW-1:0]     b_lo;
  logic [AXW-1:0]     b_hi;
  logic [AXW-1:0]     b_wr;
  logic [AXW-1:0]     rd_addr;
  logic [WW-1:0]      span;
  logic [WW-1:0]      half;
  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  logic [VB-1:0]      mem_wd;
  logic               gcd_busy;
  logic               gcd_done;
  logic [VB-1:0]      gcd_res;
  logic [VB+31:0]     res_ext;
  logic               out_free;
  logic               is_load;

  assign is_load  = cmd.cap && (in_data.req_type == ReqLoad);
  assign eff_cnt  = open_r ? cnt_r : '0;
  assign room     = eff_cnt < CW'(MAX_ENTRIES);
  assign load_ext = {{VB{1'b0}}, in_data.value};
  assign load_val = load_ext[VB-1:0];

  // query decode
  assign len = {1'b0, qr_r} - {1'b0, ql_r} + LenBits'(1);
  always_comb begin
    k = '0;
    for (int i = 0; i < LenBits; i++) begin
      if (len[i]) k = KBits'(i);
    end
  end
  assign q_lo = AXW'(k) * AXW'(MAX_ENTRIES) + AXW'(ql_r);
  assign q_hi = AXW'(k) * AXW'(MAX_ENTRIES) + AXW'(qr_r) + AXW'(1)
              - (AXW'(1) << k);
  assign sts.q_ok = ready_r && (ql_r <= qr_r) && (AXW'(qr_r) < AXW'(cnt_r))
                 && (int'(k) < LEVELS);

  // build addressing
  assign span = WW'(1) << lvl_r;
  assign half = span >> 1;
  assign b_lo = AXW'(lvl_r - LVW'(1)) * AXW'(MAX_ENTRIES) + AXW'(idx_r);
  assign b_hi = b_lo + AXW'(half);
  assign b_wr = AXW'(lvl_r) * AXW'(MAX_ENTRIES) + AXW'(idx_r);
  assign sts.lvl_ok = (int'(lvl_r) < LEVELS) && (span <= WW'(cnt_r));
  assign sts.row_ok = (WW'(idx_r) + span) <= WW'(cnt_r);

  always_comb begin
    unique case (cmd.rd_sel)
      RD_Q_LO: rd_addr = q_lo;
      RD_Q_HI: rd_addr = q_hi;
      RD_B_LO: rd_addr = b_lo;
      RD_B_HI: rd_addr = b_hi;
      default: rd_addr = b_lo;
    endcase
  end

  assign mem_we = (is_load && room) || cmd.wr_build;
  assign mem_wa = cmd.wr_build ? b_wr[AW-1:0] : AW'(eff_cnt);
  assign mem_wd = cmd.wr_build ? gcd_res : load_val;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data_r <= mem[rd_addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      ready_r <= 1'b0;
      open_r  <= 1'b0;
      ovf_r   <= 1'b0;
      lvl_r   <= '0;
      idx_r   <= '0;
    end else begin
      if (is_load) begin
        if (!open_r) ready_r <= 1'b0;
        open_r <= !in_data.last_element;
        if (room) begin
          cnt_r <= eff_cnt + CW'(1);
        end else begin
          cnt_r <= eff_cnt;
          ovf_r <= 1'b1;
        end
      end
      if (cmd.bld_init) begin
        lvl_r <= LVW'(1);
        idx_r <= '0;
      end else if (cmd.next_level) begin
        lvl_r <= lvl_r + LVW'(1);
        idx_r <= '0;
      end else if (cmd.next_row) begin
        idx_r <= idx_r + CW'(1);
      end
      if (cmd.bld_done) ready_r <= (cnt_r != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      ql_r <= in_data.left_index;
      qr_r <= in_data.right_index;
    end
    if (cmd.opa_ld) opa_r <= rd_data_r;
  end

  sptg_gcd #(
    .VALUE_BITS(VALUE_BITS)
  ) u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.gcd_start),
    .a     (opa_r),
    .b     (rd_data_r),
    .busy  (gcd_busy),
    .done  (gcd_done),
    .result(gcd_res)
  );

  assign sts.gcd_done = gcd_done;
  assign res_ext      = {32'b0, gcd_res};

  // result register
  assign out_free     = !out_valid_r || !out_stall;
  assign sts.out_free = out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_r.gcd_value     <= sts.q_ok ? res_ext[31:0] : 32'd0;
      out_r.error_flag    <= !sts.q_ok;
      out_r.overflow_flag <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_ENTRIES)) else $error("entry count beyond capacity");
  a_gcd_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.gcd_start |-> !gcd_busy) else $error("gcd started while busy");
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> out_free) else $error("result overwritten while held");

endmodule

>>> rtl/sptg_ctrl.sv
// ----------------------------------------------------------------------------
// sptg_ctrl
// sequencer for loads, table build and queries
// ----------------------------------------------------------------------------
module sptg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                req_type,
  input  logic                last_element,
  output logic                in_stall,
  output sptg_pkg::sptg_cmd_t cmd,
  input  sptg_pkg::sptg_sts_t sts
);
  import sptg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_Q_EVAL,
    S_Q_RDA,
    S_Q_RDB,
    S_Q_GCD,
    S_Q_OUT,
    S_B_CHK,
    S_B_RDA,
    S_B_RDB,
    S_B_GCD,
    S_B_WR
  } state_t;

  state_t state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (req_type == ReqQuery) state_r <= S_Q_EVAL;
            else if (last_element)    state_r <= S_B_CHK;
          end
        end
        S_Q_EVAL: state_r <= sts.q_ok ? S_Q_RDA : S_Q_OUT;
        S_Q_RDA:  state_r <= S_Q_RDB;
        S_Q_RDB:  state_r <= S_Q_GCD;
        S_Q_GCD:  if (sts.gcd_done) state_r <= S_Q_OUT;
        S_Q_OUT:  if (sts.out_free) state_r <= S_IDLE;
        S_B_CHK: begin
          if (!sts.lvl_ok)     state_r <= S_IDLE;
          else if (sts.row_ok) state_r <= S_B_RDA;
        end
        S_B_RDA:  state_r <= S_B_RDB;
        S_B_RDB:  state_r <= S_B_GCD;
        S_B_GCD:  if (sts.gcd_done) state_r <= S_B_WR;
        S_B_WR:   state_r <= S_B_CHK;
        default:  state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_Q_LO;
    unique case (state_r)
      S_IDLE: begin
        cmd.cap      = in_valid;
        cmd.bld_init = in_valid && (req_type == ReqLoad) && last_element;
      end
      S_Q_EVAL: cmd.rd_sel = RD_Q_LO;
      S_Q_RDA: begin
        cmd.rd_sel = RD_Q_HI;
        cmd.opa_ld = 1'b1;
      end
      S_Q_RDB:  cmd.gcd_start = 1'b1;
      S_Q_GCD:  cmd.rd_sel = RD_Q_LO;
      S_Q_OUT:  cmd.out_ld = sts.out_free;
      S_B_CHK: begin
        cmd.rd_sel     = RD_B_LO;
        cmd.bld_done   = !sts.lvl_ok;
        cmd.next_level = sts.lvl_ok && !sts.row_ok;
      end
      S_B_RDA: begin
        cmd.rd_sel = RD_B_HI;
        cmd.opa_ld = 1'b1;
      end
      S_B_RDB:  cmd.gcd_start = 1'b1;
      S_B_GCD:  cmd.rd_sel = RD_B_LO;
      S_B_WR: begin
        cmd.wr_build = 1'b1;
        cmd.next_row = 1'b1;
      end
      default:  cmd.rd_sel = RD_Q_LO;
    endcase
  end

endmodule

>>> rtl/sparse_table_range_gcd.sv
// ----------------------------------------------------------------------------
// sparse_table_range_gcd
// range gcd queries answered from a sparse table of block gcds
// ----------------------------------------------------------------------------
// input channel (in_valid/in_stall/in_data): a load beat appends value to the
// array; the load beat with last_element set closes it and builds the table.
// a query beat asks for the gcd of [left_index, right_index].
// result channel (out_valid/out_stall/out_data): one beat per query, none for
// loads. error_flag marks a bad range or no built table; overflow_flag is the
// sticky flag for loads dropped beyond MAX_ENTRIES.
// one item at a time: in_stall is low only while the sequencer is idle.
// a load is taken in the idle state. a query reads its two table entries
// through the single read port of the table memory and then runs the gcd
// unit, one step per cycle, before the result register is loaded.
// a build reads two entries and runs the gcd unit for each table entry
// written, row by row and level by level.
// reset clears the counters and flags; the table needs no clearing pass.
// a result waiting under out_stall holds; loads are still taken meanwhile,
// the next query waits for the result register to free.
// ----------------------------------------------------------------------------
module sparse_table_range_gcd #(
  parameter int unsigned MAX_ENTRIES = 1024,
  parameter int unsigned LEVELS      = 11,
  parameter int unsigned VALUE_BITS  = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sptg_pkg::sptg_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sptg_pkg::sptg_out_t out_data
);
  import sptg_pkg::*;

  sptg_cmd_t cmd;
  sptg_sts_t sts;

  sptg_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .req_type    (in_data.req_type),
    .last_element(in_data.last_element),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .sts         (sts)
  );

  sptg_dp #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .LEVELS     (LEVELS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_data (out_data),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks range gcd answers of sparse_table_range_gcd against a local array
// ----------------------------------------------------------------------------
// loads and queries go in through the input channel with random gaps; each
// query's answer is predicted by a direct gcd fold over the loaded values and
// compared field by field with the returned beat. covers query before build,
// bad ranges, whole-array ranges, zeros, overflow and the sticky flag.
// ----------------------------------------------------------------------------
module testbench;
  import sptg_pkg::*;

  localparam int unsigned Capacity = 1024;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  sptg_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  sptg_out_t out_data;

  sparse_table_range_gcd dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #4 clk = ~clk;

  // local copy of the array and flags
  logic [31:0]  loaded_vals [Capacity];
  int unsigned  loaded_cnt = 0;
  bit           table_built = 0;
  bit           array_open = 0;
  bit           dropped_sticky = 0;
  sptg_out_t    pending_answers [$];
  int unsigned  fail_count = 0;
  int unsigned  load_beats = 0;
  int unsigned  query_beats = 0;
  int unsigned  answers_checked = 0;
  bit           no_gaps = 0;

  function automatic logic [31:0] gcd_of(logic [31:0] a, logic [31:0] b);
    logic [31:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic sptg_out_t range_gcd(int unsigned lo, int unsigned hi);
    sptg_out_t r;
    r = '0;
    r.overflow_flag = dropped_sticky;
    if (!table_built || lo > hi || hi >= loaded_cnt) begin
      r.error_flag = 1'b1;
    end else begin
      for (int unsigned i = lo; i <= hi; i++) r.gcd_value = gcd_of(r.gcd_value, loaded_vals[i]);
    end
    return r;
  endfunction

  function automatic void apply_load(logic [31:0] v, logic last);
    if (!array_open) begin
      loaded_cnt = 0;
      table_built = 0;
      array_open = 1;
    end
    if (loaded_cnt < Capacity) begin
      loaded_vals[loaded_cnt] = v;
      loaded_cnt++;
    end else begin
      dropped_sticky = 1;
    end
    if (last) begin
      array_open = 0;
      table_built = (loaded_cnt > 0);
    end
  endfunction

  function automatic int unsigned gap_len();
    if (no_gaps) return 0;
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 1);
    return $urandom_range(2, 25);
  endfunction

  task automatic send_item(logic req, logic [31:0] v, logic last, int unsigned lo, int unsigned hi);
    int unsigned g;
    in_valid <= 1'b1;
    in_data.req_type <= req;
    in_data.value <= v;
    in_data.last_element <= last;
    in_data.left_index <= lo[IdxBits-1:0];
    in_data.right_index <= hi[IdxBits-1:0];
    do @(posedge clk); while (in_stall);
    if (req == ReqLoad) begin
      apply_load(v, last);
      load_beats++;
    end else begin
      pending_answers.push_back(range_gcd(lo[IdxBits-1:0], hi[IdxBits-1:0]));
      query_beats++;
    end
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic load_array(int unsigned n, logic [31:0] factor, int unsigned spread);
    logic [31:0] v;
    for (int unsigned i = 0; i < n; i++) begin
      v = ($urandom_range(0, 15) == 0) ? $urandom() : factor * $urandom_range(0, spread);
      send_item(ReqLoad, v, i == n - 1, $urandom_range(0, 1023), $urandom_range(0, 1023));
    end
  endtask

  task automatic random_query();
    int unsigned lo, hi;
    if (loaded_cnt > 0 && $urandom_range(0, 9) < 8) begin
      lo = $urandom_range(0, loaded_cnt - 1);
      hi = $urandom_range(lo, loaded_cnt - 1);
      if ($urandom_range(0, 9) == 0) begin
        lo = 0;
        hi = loaded_cnt - 1;
      end
    end else begin
      lo = $urandom_range(0, 1023);
      hi = $urandom_range(0, 1023);
    end
    send_item(ReqQuery, $urandom(), $urandom_range(0, 1), lo, hi);
  endtask

  // result stall pattern
  always @(posedge clk) begin
    if (no_gaps) out_stall <= 1'b0;
    else if ($urandom_range(0, 9) < 7) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 3) != 0);
  end

  // answer checker
  always @(posedge clk) begin
    sptg_out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        $error("unexpected result beat gcd_value=%h", out_data.gcd_value);
        fail_count++;
      end else begin
        e = pending_answers.pop_front();
        answers_checked++;
        if (out_data.gcd_value !== e.gcd_value) begin
          $error("gcd_value expected %h actual %h", e.gcd_value, out_data.gcd_value);
          fail_count++;
        end
        if (out_data.error_flag !== e.error_flag) begin
          $error("error_flag expected %b actual %b", e.error_flag, out_data.error_flag);
          fail_count++;
        end
        if (out_data.overflow_flag !== e.overflow_flag) begin
          $error("overflow_flag expected %b actual %b", e.overflow_flag, out_data.overflow_flag);
          fail_count++;
        end
      end
    end
  end

  task automatic test_directed();
    send_item(ReqQuery, 32'h0, 1'b0, 0, 0);
    send_item(ReqLoad, 32'hFFFF_FFFF, 1'b0, 0, 0);
    send_item(ReqQuery, 32'h0, 1'b0, 0, 0);
    send_item(ReqLoad, 32'h0, 1'b0, 0, 0);
    send_item(ReqLoad, 32'h0, 1'b0, 1023, 1023);
    send_item(ReqLoad, 32'd12, 1'b0, 0, 0);
    send_item(ReqLoad, 32'd18, 1'b0, 0, 0);
    send_item(ReqLoad, 32'hFFFF_FFFE, 1'b1, 0, 0);
    send_item(ReqQuery, 32'h0, 1'b0, 0, 4);
    send_item(ReqQuery, 32'h0, 1'b0, 0, 3);
    send_item(ReqQuery, 32'h0, 1'b0, 1, 2);
    send_item(ReqQuery, 32'h0, 1'b0, 0, 0);
    send_item(ReqQuery, 32'h0, 1'b0, 4, 4);
    send_item(ReqQuery, 32'h0, 1'b0, 3, 4);
    send_item(ReqQuery, 32'h0, 1'b0, 3, 2);
    send_item(ReqQuery, 32'h0, 1'b0, 0, 5);
    send_item(ReqQuery, 32'hFFFF_FFFF, 1'b1, 1023, 1023);
    send_item(ReqQuery, 32'h0, 1'b0, 1023, 0);
    send_item(ReqLoad, 32'd7, 1'b1, 0, 0);
    send_item(ReqQuery, 32'h0, 1'b0, 0, 0);
    send_item(ReqQuery, 32'h0, 1'b0, 0, 1);
  endtask

  task automatic test_random_arrays(int unsigned item_budget);
    int unsigned start;
    start = load_beats + query_beats;
    while (load_beats + query_beats - start < item_budget) begin
      no_gaps = ($urandom_range(0, 5) == 0);
      load_array($urandom_range(1, 24), $urandom_range(1, 1 << $urandom_range(0, 20)),
                 $urandom_range(1, 1000));
      if ($urandom_range(0, 4) == 0) send_item(ReqQuery, 32'h0, 1'b0, 0, 0);
      repeat ($urandom_range(3, 20)) random_query();
    end
    no_gaps = 0;
  endtask

  task automatic test_overflow();
    load_array(Capacity + 6, 32'd6, 5000);
    send_item(ReqQuery, 32'h0, 1'b0, 0, Capacity - 1);
    send_item(ReqQuery, 32'h0, 1'b0, 1, Capacity - 1);
    send_item(ReqQuery, 32'h0, 1'b0, Capacity - 1, Capacity - 1);
    send_item(ReqQuery, 32'h0, 1'b0, 0, 511);
    repeat (30) random_query();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_arrays(500);
    test_overflow();
    test_random_arrays(300);
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("covered %0d load beats and %0d query beats, %0d answers checked",
             load_beats, query_beats, answers_checked);
    $display("including query before build, bad ranges, whole array and overflow");
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #400_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

>>> filelist.f
rtl/sptg_pkg.sv
rtl/sptg_gcd.sv
rtl/sptg_dp.sv
rtl/sptg_ctrl.sv
rtl/sparse_table_range_gcd.sv
test/testbench.sv
